// ----- hw/rtl/mi3_pkg.sv -----
// Shared types, constants and fixed-point helpers for the 3x3 matrix inverter.
package mi3_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int THR_W     = 31;
	localparam int COLS      = 6;
	localparam int MEM_DEPTH = 18;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int QUO_W     = 2 * FRAC_W + 1;
	localparam int DCNT_W    = $clog2(QUO_W + 1);
	localparam int NENT      = 9;

	typedef logic signed [DATA_W-1:0]   data_t;
	typedef logic [DATA_W-1:0]          umag_t;
	typedef logic signed [2*DATA_W-1:0] wide_t;
	typedef logic [QUO_W-1:0]           quo_t;
	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [1:0]                 row_t;
	typedef logic [2:0]                 col_t;
	typedef logic [3:0]                 ent_t;

	localparam data_t DMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DMIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam data_t ONE  = data_t'(64'd1 << FRAC_W);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SING = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_PIV, S_PCHK, S_DIV, S_SCALE,
		S_FRD, S_FCAP, S_ELIM, S_OWAIT, S_OUT, S_FIN
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		addr_t raddr0;
		addr_t raddr1;
	} mem_req_t;

	typedef struct packed {
		logic  we;
		ent_t  idx;
		data_t data;
	} res_wr_t;

	typedef struct packed {
		logic  sat;
		data_t val;
	} sres_t;

	function automatic addr_t addr_of(row_t r, col_t c);
		return addr_t'(int'(r) * COLS + int'(c));
	endfunction

	function automatic umag_t mag(data_t v);
		return v[DATA_W-1] ? umag_t'(-v) : umag_t'(v);
	endfunction

	// product already in full precision; floor shift then clamp
	function automatic sres_t qmul_fin(wide_t p);
		wide_t sh;
		sres_t r;
		sh = p >>> FRAC_W;
		if ((&sh[2*DATA_W-1:DATA_W-1]) || !(|sh[2*DATA_W-1:DATA_W-1])) begin
			r.sat = 1'b0;
			r.val = sh[DATA_W-1:0];
		end else begin
			r.sat = 1'b1;
			r.val = sh[2*DATA_W-1] ? DMIN : DMAX;
		end
		return r;
	endfunction

	function automatic sres_t qsub(data_t a, data_t b);
		logic signed [DATA_W:0] d;
		sres_t r;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] == d[DATA_W-1]) begin
			r.sat = 1'b0;
			r.val = d[DATA_W-1:0];
		end else begin
			r.sat = 1'b1;
			r.val = d[DATA_W] ? DMIN : DMAX;
		end
		return r;
	endfunction

	function automatic sres_t recip_sat(logic neg, quo_t q);
		sres_t r;
		if (!neg) begin
			r.sat = |q[QUO_W-1:DATA_W-1];
			r.val = r.sat ? DMAX : data_t'(q[DATA_W-1:0]);
		end else begin
			r.sat = (|q[QUO_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]));
			r.val = r.sat ? DMIN : data_t'(-q[DATA_W-1:0]);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/mi3_if.sv -----
// Request channels: matrix in, inverse out.
interface mi3_mat_if import mi3_pkg::*;;
	logic  valid;
	logic  ready;
	data_t a_r0c0, a_r0c1, a_r0c2;
	data_t a_r1c0, a_r1c1, a_r1c2;
	data_t a_r2c0, a_r2c1, a_r2c2;

	modport source (output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
		a_r2c0, a_r2c1, a_r2c2, input ready);
	modport sink (input valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
		a_r2c0, a_r2c1, a_r2c2, output ready);
endinterface

interface mi3_inv_if import mi3_pkg::*;;
	logic       valid;
	logic       ready;
	data_t      inv_r0c0, inv_r0c1, inv_r0c2;
	data_t      inv_r1c0, inv_r1c1, inv_r1c2;
	data_t      inv_r2c0, inv_r2c1, inv_r2c2;
	logic [1:0] status;

	modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, status, input ready);
	modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, status, output ready);
endinterface

// ----- hw/rtl/mi3_mem.sv -----
// 3x6 augmented-matrix store: one write port, two registered read ports.
module mi3_mem import mi3_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output data_t    rd0,
	output data_t    rd1
);

	data_t mem_q [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd0 <= mem_q[req.raddr0];
		rd1 <= mem_q[req.raddr1];
	end

endmodule

// ----- hw/rtl/mi3_div.sv -----
// Restoring divider: 2^(2*FRAC_W) / divisor, one quotient bit per cycle.
module mi3_div import mi3_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  umag_t divisor,
	output logic  done,
	output quo_t  quo
);

	logic              run_q, done_q;
	logic [DCNT_W-1:0] cnt_q;
	umag_t             rem_q, dvs_q;
	quo_t              quo_q;
	logic [DATA_W:0]   trial;
	logic              qbit;

	// dividend is a single one in the top bit, so only the first step shifts in a one
	always_comb begin
		trial = {rem_q, (cnt_q == '0)};
		qbit  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			if (cnt_q == DCNT_W'(QUO_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= qbit ? umag_t'(trial - {1'b0, dvs_q}) : umag_t'(trial);
			quo_q <= {quo_q[QUO_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- hw/rtl/mi3_ctrl.sv -----
// Elimination sequencer: load, pivot search, scaling, row updates and readout.
module mi3_ctrl import mi3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  data_t            ain [NENT],
	input  logic [THR_W-1:0] thr,
	input  logic             out_busy,
	output logic             idle,
	output mem_req_t         mreq,
	input  data_t            rd0,
	input  data_t            rd1,
	output logic             div_start,
	output umag_t            div_divisor,
	input  logic             div_done,
	input  quo_t             div_quo,
	output res_wr_t          res,
	output logic             fin,
	output status_t          fin_status
);

	state_t state_q, state_d;
	col_t   cnt_q;
	row_t   col_q, row_q, bi_q;
	row_t   perm_q [3];
	data_t  ain_q [NENT];
	umag_t  best_q;
	logic   bneg_q;
	data_t  recip_q, f_q;
	logic   sat_q, sing_q;
	logic   v_s1, v_s2;
	col_t   k_s1, k_s2;
	wide_t  prod_s2;
	data_t  old_s2;

	logic   issue;
	sres_t  qm, qs, rc;
	data_t  mul_a;
	logic [2:0] r_nxt;

	always_comb begin
		qm    = qmul_fin(prod_s2);
		qs    = qsub(old_s2, qm.val);
		rc    = recip_sat(bneg_q, div_quo);
		mul_a = (state_q == S_SCALE) ? recip_q : f_q;
		r_nxt = {1'b0, row_q} + 3'd1;
		if (r_nxt == {1'b0, col_q}) begin
			r_nxt = r_nxt + 3'd1;
		end
	end

	always_comb begin
		state_d     = state_q;
		issue       = 1'b0;
		idle        = 1'b0;
		div_start   = 1'b0;
		div_divisor = best_q;
		fin         = 1'b0;
		fin_status  = sing_q ? ST_SING : (sat_q ? ST_SAT : ST_OK);
		mreq        = '0;
		res         = '0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) state_d = S_LOAD;
			end
			S_LOAD: begin
				mreq.we    = 1'b1;
				mreq.waddr = addr_of(row_q, cnt_q);
				if (cnt_q < 3'd3) begin
					mreq.wdata = ain_q[ent_t'(int'(row_q) * 3 + int'(cnt_q[1:0]))];
				end else begin
					mreq.wdata = (cnt_q == {1'b0, row_q} + 3'd3) ? ONE : '0;
				end
				if (row_q == 2'd2 && cnt_q == 3'd5) state_d = S_PIV;
			end
			S_PIV: begin
				issue       = cnt_q < 3'd3;
				mreq.raddr0 = addr_of(perm_q[cnt_q[1:0]], {1'b0, col_q});
				if (!issue && !v_s1) state_d = S_PCHK;
			end
			S_PCHK: begin
				if (best_q == '0 || best_q < {1'b0, thr}) begin
					state_d = S_OWAIT;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) state_d = S_SCALE;
			end
			S_SCALE: begin
				issue       = cnt_q < 3'd6;
				mreq.raddr0 = addr_of(perm_q[col_q], cnt_q);
				mreq.we     = v_s2;
				mreq.waddr  = addr_of(perm_q[col_q], k_s2);
				mreq.wdata  = qm.val;
				if (!issue && !v_s1 && !v_s2) state_d = S_FRD;
			end
			S_FRD: begin
				mreq.raddr1 = addr_of(perm_q[row_q], {1'b0, col_q});
				state_d     = S_FCAP;
			end
			S_FCAP: begin
				state_d = S_ELIM;
			end
			S_ELIM: begin
				issue       = cnt_q < 3'd6;
				mreq.raddr0 = addr_of(perm_q[col_q], cnt_q);
				mreq.raddr1 = addr_of(perm_q[row_q], cnt_q);
				mreq.we     = v_s2;
				mreq.waddr  = addr_of(perm_q[row_q], k_s2);
				mreq.wdata  = qs.val;
				if (!issue && !v_s1 && !v_s2) begin
					if (r_nxt < 3'd3) state_d = S_FRD;
					else if (col_q == 2'd2) state_d = S_OWAIT;
					else state_d = S_PIV;
				end
			end
			S_OWAIT: begin
				if (!out_busy) state_d = sing_q ? S_FIN : S_OUT;
			end
			S_OUT: begin
				issue       = cnt_q < 3'd6;
				mreq.raddr0 = addr_of(perm_q[row_q], cnt_q);
				res.we      = v_s1;
				res.idx     = ent_t'(int'(row_q) * 3 + int'(k_s1) - 3);
				res.data    = rd0;
				if (!issue && !v_s1 && row_q == 2'd2) state_d = S_FIN;
			end
			S_FIN: begin
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1 && (state_q == S_SCALE || state_q == S_ELIM);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cnt_q <= cnt_q + 3'd1;
			k_s1  <= cnt_q;
		end
		k_s2    <= k_s1;
		prod_s2 <= wide_t'(mul_a) * wide_t'(rd0);
		old_s2  <= rd1;
		if (v_s2 && state_q == S_SCALE) sat_q <= sat_q | qm.sat;
		if (v_s2 && state_q == S_ELIM) sat_q <= sat_q | qm.sat | qs.sat;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ain_q     <= ain;
					cnt_q     <= '0;
					row_q     <= '0;
					col_q     <= '0;
					perm_q[0] <= 2'd0;
					perm_q[1] <= 2'd1;
					perm_q[2] <= 2'd2;
					sat_q     <= 1'b0;
					sing_q    <= 1'b0;
				end
			end
			S_LOAD: begin
				if (cnt_q == 3'd5) begin
					cnt_q <= '0;
					row_q <= row_q + 2'd1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
				best_q <= '0;
				bi_q   <= '0;
				bneg_q <= 1'b0;
			end
			S_PIV: begin
				// first row with the strictly largest magnitude wins
				if (v_s1 && mag(rd0) > best_q) begin
					best_q <= mag(rd0);
					bi_q   <= k_s1[1:0];
					bneg_q <= rd0[DATA_W-1];
				end
			end
			S_PCHK: begin
				if (best_q == '0 || best_q < {1'b0, thr}) begin
					sing_q <= 1'b1;
				end else begin
					perm_q[col_q] <= perm_q[bi_q];
					perm_q[bi_q]  <= perm_q[col_q];
				end
			end
			S_DIV: begin
				if (div_done) begin
					recip_q <= rc.val;
					sat_q   <= sat_q | rc.sat;
					cnt_q   <= '0;
				end
			end
			S_SCALE: begin
				row_q <= (col_q == 2'd0) ? 2'd1 : 2'd0;
			end
			S_FCAP: begin
				f_q   <= rd1;
				cnt_q <= '0;
			end
			S_ELIM: begin
				if (!issue && !v_s1 && !v_s2) begin
					if (r_nxt < 3'd3) begin
						row_q <= r_nxt[1:0];
					end else if (col_q != 2'd2) begin
						col_q  <= col_q + 2'd1;
						cnt_q  <= {1'b0, col_q} + 3'd1;
						bi_q   <= col_q + 2'd1;
						best_q <= '0;
						bneg_q <= 1'b0;
					end
				end
			end
			S_OWAIT: begin
				cnt_q <= 3'd3;
				row_q <= '0;
			end
			S_OUT: begin
				if (!issue && !v_s1 && row_q != 2'd2) begin
					row_q <= row_q + 2'd1;
					cnt_q <= 3'd3;
				end
			end
			S_FRD, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/matrix_inverse_3x3_core.sv -----
// Top level of the 3x3 Gauss-Jordan matrix inverter.
// One matrix at a time. The time from acceptance to result (shorter when a pivot falls below
// the threshold) is set mostly by the 33-step pivot reciprocal divider, run three times, and
// by the single write port of the 3x6 store, through which every element update passes one
// per cycle. The result sits in an output register, so the next matrix is accepted while it
// waits to be taken. singular_threshold (31 bits, reset 1) is written through thr_we/thr_wdata;
// the user must write it only while idle, and the block itself does not enforce this.
module matrix_inverse_3x3_core import mi3_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	mi3_mat_if.sink          mat,
	mi3_inv_if.source        inv,
	input  logic             thr_we,
	input  logic [THR_W-1:0] thr_wdata
);

	logic [THR_W-1:0] thr_q;
	data_t            inv_q [NENT];
	status_t          status_q;
	logic             valid_q;

	data_t    ain [NENT];
	logic     idle, start, fin, div_start, div_done;
	status_t  fin_status;
	mem_req_t mreq;
	data_t    rd0, rd1;
	umag_t    div_divisor;
	quo_t     div_quo;
	res_wr_t  res;

	assign ain[0] = mat.a_r0c0;
	assign ain[1] = mat.a_r0c1;
	assign ain[2] = mat.a_r0c2;
	assign ain[3] = mat.a_r1c0;
	assign ain[4] = mat.a_r1c1;
	assign ain[5] = mat.a_r1c2;
	assign ain[6] = mat.a_r2c0;
	assign ain[7] = mat.a_r2c1;
	assign ain[8] = mat.a_r2c2;

	assign mat.ready = idle;
	assign start     = mat.valid && idle;

	mi3_ctrl u_ctrl (
		.clk, .arst_n, .start, .ain, .thr(thr_q), .out_busy(valid_q), .idle,
		.mreq, .rd0, .rd1, .div_start, .div_divisor, .div_done, .div_quo,
		.res, .fin, .fin_status
	);

	mi3_mem u_mem (.clk, .req(mreq), .rd0, .rd1);

	mi3_div u_div (
		.clk, .arst_n, .start(div_start), .divisor(div_divisor),
		.done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_W'(1);
			valid_q <= 1'b0;
		end else begin
			if (thr_we) thr_q <= thr_wdata;
			if (fin) valid_q <= 1'b1;
			else if (inv.ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.we) inv_q[res.idx] <= res.data;
		if (fin) begin
			status_q <= fin_status;
			if (fin_status == ST_SING) begin
				for (int i = 0; i < NENT; i++) inv_q[i] <= '0;
			end
		end
	end

	assign inv.valid    = valid_q;
	assign inv.status   = status_q;
	assign inv.inv_r0c0 = inv_q[0];
	assign inv.inv_r0c1 = inv_q[1];
	assign inv.inv_r0c2 = inv_q[2];
	assign inv.inv_r1c0 = inv_q[3];
	assign inv.inv_r1c1 = inv_q[4];
	assign inv.inv_r1c2 = inv_q[5];
	assign inv.inv_r2c0 = inv_q[6];
	assign inv.inv_r2c1 = inv_q[7];
	assign inv.inv_r2c2 = inv_q[8];

endmodule

// ----- hw/rtl/mi3_chk.sv -----
// Port-level checks for the matrix inverter, bound to the top level.
module mi3_chk import mi3_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [31:0] inv_any
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_SING || status == ST_SAT))
		else $error("undefined status code");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_SING |-> inv_any == '0)
		else $error("singular result with non-zero entries");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result dropped or changed");

endmodule

bind matrix_inverse_3x3_core mi3_chk u_mi3_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (mat.valid),
	.in_ready  (mat.ready),
	.out_valid (inv.valid),
	.out_ready (inv.ready),
	.status    (inv.status),
	.inv_any   (inv.inv_r0c0 | inv.inv_r0c1 | inv.inv_r0c2 | inv.inv_r1c0 | inv.inv_r1c1
		| inv.inv_r1c2 | inv.inv_r2c0 | inv.inv_r2c1 | inv.inv_r2c2)
);
